>>> rtl/core/esic_pkg.sv
// ----------------------------------------------------------------------------
// esic_pkg
// Shared types and constants of the integer sensor compensation pipeline.
// ----------------------------------------------------------------------------
package esic_pkg;

	// Configuration register indexes (register i sits at byte address 8*i).
	typedef enum logic [2:0] {
		REG_TEMP     = 3'd0,
		REG_PRESS_LO = 3'd1,
		REG_PRESS_HI = 3'd2,
		REG_MIXED    = 3'd3,
		REG_HUM      = 3'd4
	} reg_idx_t;

	// Compensation constants.
	localparam logic [63:0] TFINE_P_OFS  = 64'd128000;
	localparam logic [20:0] P_FULL_SCALE = 21'd1048576;
	localparam logic [63:0] P_SCALE      = 64'd3125;
	localparam logic [63:0] P_BIAS_47    = 64'h0000_8000_0000_0000;
	localparam logic [31:0] TFINE_H_OFS  = 32'd76800;
	localparam logic [31:0] H_CLAMP_MAX  = 32'd419430400;
	localparam logic [31:0] H_OFS_2M     = 32'd2097152;
	localparam logic [31:0] H_OFS_32K    = 32'd32768;
	localparam logic [31:0] H_RND_8K     = 32'd8192;
	localparam logic [31:0] H_RND_16K    = 32'd16384;
	localparam logic [31:0] T_RND        = 32'd128;

	// Pipeline latencies.
	localparam int MUL_LAT = 2;
	localparam int DIV_LAT = 66;
	localparam int OUT_LAT = 85;

endpackage

>>> rtl/core/esic_if.sv
// ----------------------------------------------------------------------------
// esic_in_if / esic_out_if
// Valid/ready channels for raw sample items and compensated result items.
// ----------------------------------------------------------------------------
interface esic_in_if;
	logic        valid;
	logic        ready;
	logic [19:0] raw_temperature;
	logic [19:0] raw_pressure;
	logic [15:0] raw_humidity;

	modport source (output valid, output raw_temperature, output raw_pressure,
		output raw_humidity, input ready);
	modport sink (input valid, input raw_temperature, input raw_pressure,
		input raw_humidity, output ready);
endinterface

interface esic_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] temperature_centi;
	logic signed [31:0] fine_temperature;
	logic        [31:0] pressure_q24_8;
	logic               pressure_valid;
	logic        [16:0] humidity_q22_10;

	modport source (output valid, output temperature_centi, output fine_temperature,
		output pressure_q24_8, output pressure_valid, output humidity_q22_10,
		input ready);
	modport sink (input valid, input temperature_centi, input fine_temperature,
		input pressure_q24_8, input pressure_valid, input humidity_q22_10,
		output ready);
endinterface

>>> rtl/core/esic_mul64.sv
// ----------------------------------------------------------------------------
// esic_mul64
// Two-stage 64x64 multiplier giving the low 64 bits of the product.
// ----------------------------------------------------------------------------
module esic_mul64 (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);
	logic [63:0] ll_s1;
	logic [31:0] lh_s1;
	logic [31:0] hl_s1;
	logic [63:0] p_s2;
	logic [31:0] mid_sum;

	// First stage: three 32x32 partial products; the high-high one falls off.
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a[31:0] * b[31:0];
			lh_s1 <= a[31:0] * b[63:32];
			hl_s1 <= a[63:32] * b[31:0];
		end
	end

	// Second stage: add the cross terms into the upper word.
	assign mid_sum = lh_s1 + hl_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= ll_s1 + {mid_sum, 32'd0};
		end
	end

	assign p = p_s2;
endmodule

>>> rtl/core/esic_delay.sv
// ----------------------------------------------------------------------------
// esic_delay
// Stallable delay line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module esic_delay #(
	parameter int W = 32,
	parameter int N = 2
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] tap_s [N];

	// Each tap moves one place when the pipeline advances.
	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= d;
			for (int i = 1; i < N; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign q = tap_s[N-1];
endmodule

>>> rtl/core/esic_div.sv
// ----------------------------------------------------------------------------
// esic_div
// Pipelined signed divider, 64-bit dividend by 32-bit divisor, one quotient
// bit per stage, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module esic_div (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic [63:0] quotient
);
	logic [63:0] w_s   [65];
	logic [31:0] r_s   [65];
	logic [31:0] mb_s  [65];
	logic        neg_s [65];
	logic [63:0] q_s;

	// Prepare magnitudes and the sign of the result.
	always_ff @(posedge clk) begin
		if (en) begin
			w_s[0]   <= dividend[63] ? (64'd0 - dividend) : dividend;
			mb_s[0]  <= divisor[31] ? (32'd0 - divisor) : divisor;
			r_s[0]   <= 32'd0;
			neg_s[0] <= dividend[63] ^ divisor[31];
		end
	end

	// Restoring division steps: shift one dividend bit into the remainder.
	for (genvar i = 0; i < 64; i++) begin : g_step
		logic [32:0] rs;
		logic [32:0] diff;
		logic        ge;

		assign rs   = {r_s[i], w_s[i][63]};
		assign diff = rs - {1'b0, mb_s[i]};
		assign ge   = rs >= {1'b0, mb_s[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[i+1]   <= ge ? diff[31:0] : rs[31:0];
				w_s[i+1]   <= {w_s[i][62:0], ge};
				mb_s[i+1]  <= mb_s[i];
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	// Restore the sign of the quotient.
	always_ff @(posedge clk) begin
		if (en) begin
			q_s <= neg_s[64] ? (64'd0 - w_s[64]) : w_s[64];
		end
	end

	assign quotient = q_s;
endmodule

>>> rtl/core/env_sensor_integer_compensation.sv
// ----------------------------------------------------------------------------
// env_sensor_integer_compensation
// Each accepted raw sample item (temperature, pressure, humidity) gives one
// result item, and a new item is taken every cycle unless the result channel
// stalls. Pipeline depth is set by the pressure path: ten pipelined 64-bit
// multiplies and a 66-stage divider that settles one quotient bit per stage.
// A stall on the result channel holds the whole pipeline. The user must write
// calibration coefficients through the APB port only while the block is idle
// (the block does not enforce this); registers at byte addresses 8*i read back their stored value.
// ----------------------------------------------------------------------------
module env_sensor_integer_compensation
	import esic_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	esic_in_if.sink     in_ch,
	esic_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	// Configuration registers.
	logic [47:0] temp_coeffs_q;
	logic [63:0] press_lo_q;
	logic [63:0] press_hi_q;
	logic [55:0] mixed_q;
	logic [23:0] hum_coeffs_q;
	reg_idx_t    ridx;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			press_lo_q    <= '0;
			press_hi_q    <= '0;
			mixed_q       <= '0;
			hum_coeffs_q  <= '0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_TEMP:     temp_coeffs_q <= pwdata[47:0];
				REG_PRESS_LO: press_lo_q    <= pwdata;
				REG_PRESS_HI: press_hi_q    <= pwdata;
				REG_MIXED:    mixed_q       <= pwdata[55:0];
				REG_HUM:      hum_coeffs_q  <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (ridx)
			REG_TEMP:     prdata = {16'd0, temp_coeffs_q};
			REG_PRESS_LO: prdata = press_lo_q;
			REG_PRESS_HI: prdata = press_hi_q;
			REG_MIXED:    prdata = {8'd0, mixed_q};
			REG_HUM:      prdata = {40'd0, hum_coeffs_q};
			default:      prdata = '0;
		endcase
	end

	// Coefficient fields, extended to the working widths.
	logic [31:0] t1, t2s, t3s;
	logic [63:0] p1, p2s, p3s, p4s, p5s, p6s, p7s, p8s, p9s;
	logic [31:0] h1, h2s, h3, h4s, h5s, h6s;

	always_comb begin
		t1  = {16'd0, temp_coeffs_q[15:0]};
		t2s = {{16{temp_coeffs_q[31]}}, temp_coeffs_q[31:16]};
		t3s = {{16{temp_coeffs_q[47]}}, temp_coeffs_q[47:32]};
		p1  = {48'd0, press_lo_q[15:0]};
		p2s = {{48{press_lo_q[31]}}, press_lo_q[31:16]};
		p3s = {{48{press_lo_q[47]}}, press_lo_q[47:32]};
		p4s = {{48{press_lo_q[63]}}, press_lo_q[63:48]};
		p5s = {{48{press_hi_q[15]}}, press_hi_q[15:0]};
		p6s = {{48{press_hi_q[31]}}, press_hi_q[31:16]};
		p7s = {{48{press_hi_q[47]}}, press_hi_q[47:32]};
		p8s = {{48{press_hi_q[63]}}, press_hi_q[63:48]};
		p9s = {{48{mixed_q[15]}}, mixed_q[15:0]};
		h1  = {24'd0, mixed_q[23:16]};
		h2s = {{16{mixed_q[39]}}, mixed_q[39:24]};
		h3  = {24'd0, mixed_q[47:40]};
		h6s = {{24{mixed_q[55]}}, mixed_q[55:48]};
		h4s = {{20{hum_coeffs_q[11]}}, hum_coeffs_q[11:0]};
		h5s = {{20{hum_coeffs_q[23]}}, hum_coeffs_q[23:12]};
	end

	// Pipeline advance and valid bits.
	logic            adv;
	logic [OUT_LAT:1] vld_q;

	assign adv         = !vld_q[OUT_LAT] || out_ch.ready;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[OUT_LAT-1:1], in_ch.valid};
		end
	end

	// Temperature stages.
	logic [31:0] v1m_s1, dd_s1, v1_s2, v2m_s2, tfine_s3, temp_s4, tfine_s4, hx_s4;
	logic [19:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4;
	logic [15:0] adch_s1, adch_s2, adch_s3, adch_s4;
	logic [63:0] pa_s4;
	logic [31:0] tdiff, tdd, tsh, v2sh, t5;

	always_comb begin
		tdiff = {15'd0, in_ch.raw_temperature[19:3]} - {t1[30:0], 1'b0};
		tdd   = {16'd0, in_ch.raw_temperature[19:4]} - t1;
		tsh   = $signed(dd_s1) >>> 12;
		v2sh  = $signed(v2m_s2) >>> 14;
		t5    = {tfine_s3[29:0], 2'b00} + tfine_s3 + T_RND;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v1m_s1   <= tdiff * t2s;
			dd_s1    <= tdd * tdd;
			adcp_s1  <= in_ch.raw_pressure;
			adch_s1  <= in_ch.raw_humidity;
			v1_s2    <= $signed(v1m_s1) >>> 11;
			v2m_s2   <= tsh * t3s;
			adcp_s2  <= adcp_s1;
			adch_s2  <= adch_s1;
			tfine_s3 <= v1_s2 + v2sh;
			adcp_s3  <= adcp_s2;
			adch_s3  <= adch_s2;
			temp_s4  <= $signed(t5) >>> 8;
			tfine_s4 <= tfine_s3;
			pa_s4    <= {{32{tfine_s3[31]}}, tfine_s3} - TFINE_P_OFS;
			hx_s4    <= tfine_s3 - TFINE_H_OFS;
			adcp_s4  <= adcp_s3;
			adch_s4  <= adch_s3;
		end
	end

	// Humidity stages, all in 32-bit wrapping arithmetic.
	logic [31:0] f1a_s5, m6_s5, m3_s5, f1_s6, g_s6, f1_s7, f2a_s7;
	logic [31:0] xx_s8, xx_s9, sq_s9, xx_s10, m1_s10;
	logic        nz_s5, nz_s6, nz_s7, nz_s8, nz_s9, nz_s10;
	logic [16:0] hum_s11;
	logic [31:0] m6sh, m3sh, gsh, f2sh, xssh, sqsh, m1sh, xf, hclamp;

	always_comb begin
		m6sh = $signed(m6_s5) >>> 10;
		m3sh = $signed(m3_s5) >>> 11;
		gsh  = $signed(g_s6) >>> 10;
		f2sh = $signed(f2a_s7) >>> 14;
		xssh = $signed(xx_s8) >>> 15;
		sqsh = $signed(sq_s9) >>> 7;
		m1sh = $signed(m1_s10) >>> 4;
		xf   = xx_s10 - m1sh;
		// Clamp to the valid humidity span before the final shift.
		if (xf[31]) begin
			hclamp = 32'd0;
		end else if (xf > H_CLAMP_MAX) begin
			hclamp = H_CLAMP_MAX;
		end else begin
			hclamp = xf;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f1a_s5  <= {2'b00, adch_s4, 14'd0} - (h4s << 20) - (h5s * hx_s4) + H_RND_16K;
			m6_s5   <= hx_s4 * h6s;
			m3_s5   <= hx_s4 * h3;
			nz_s5   <= hx_s4 != 32'd0;
			f1_s6   <= $signed(f1a_s5) >>> 15;
			g_s6    <= m6sh * (m3sh + H_OFS_32K);
			nz_s6   <= nz_s5;
			f1_s7   <= f1_s6;
			f2a_s7  <= (gsh + H_OFS_2M) * h2s + H_RND_8K;
			nz_s7   <= nz_s6;
			xx_s8   <= f1_s7 * f2sh;
			nz_s8   <= nz_s7;
			xx_s9   <= xx_s8;
			sq_s9   <= xssh * xssh;
			nz_s9   <= nz_s8;
			xx_s10  <= xx_s9;
			m1_s10  <= sqsh * h1;
			nz_s10  <= nz_s9;
			hum_s11 <= nz_s10 ? hclamp[28:12] : 17'd0;
		end
	end

	// Pressure: products of the offset terms.
	logic [63:0] aa_s6, a5_s6, a2_s6, b1_s8, a3_s8, a5_s8, a2_s8;
	logic [63:0] b_s9, tsum_s9, t_s11, b_s11, n0_s12, n_s14;
	logic [19:0] adcp_s11;
	logic [31:0] den_s12, den_s14;
	logic [63:0] a3sh, tsh64;
	logic [20:0] pinv;

	esic_mul64 u_mul_aa (.clk(clk), .en(adv), .a(pa_s4), .b(pa_s4), .p(aa_s6));
	esic_mul64 u_mul_a5 (.clk(clk), .en(adv), .a(pa_s4), .b(p5s), .p(a5_s6));
	esic_mul64 u_mul_a2 (.clk(clk), .en(adv), .a(pa_s4), .b(p2s), .p(a2_s6));
	esic_mul64 u_mul_b1 (.clk(clk), .en(adv), .a(aa_s6), .b(p6s), .p(b1_s8));
	esic_mul64 u_mul_a3 (.clk(clk), .en(adv), .a(aa_s6), .b(p3s), .p(a3_s8));

	esic_delay #(.W(64), .N(MUL_LAT)) u_dly_a5 (.clk(clk), .en(adv), .d(a5_s6), .q(a5_s8));
	esic_delay #(.W(64), .N(MUL_LAT)) u_dly_a2 (.clk(clk), .en(adv), .d(a2_s6), .q(a2_s8));

	assign a3sh = $signed(a3_s8) >>> 8;

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s9    <= b1_s8 + (a5_s8 << 17) + (p4s << 35);
			tsum_s9 <= P_BIAS_47 + a3sh + (a2_s8 << 12);
		end
	end

	// Pressure: divisor and scaled numerator.
	esic_mul64 u_mul_t (.clk(clk), .en(adv), .a(tsum_s9), .b(p1), .p(t_s11));
	esic_delay #(.W(64), .N(MUL_LAT)) u_dly_b (.clk(clk), .en(adv), .d(b_s9), .q(b_s11));
	esic_delay #(.W(20), .N(7)) u_dly_adcp (.clk(clk), .en(adv), .d(adcp_s4), .q(adcp_s11));

	assign tsh64 = $signed(t_s11) >>> 33;
	assign pinv  = P_FULL_SCALE - {1'b0, adcp_s11};

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s12 <= tsh64[31:0];
			n0_s12  <= ({43'd0, pinv} << 31) - b_s11;
		end
	end

	esic_mul64 u_mul_n (.clk(clk), .en(adv), .a(n0_s12), .b(P_SCALE), .p(n_s14));
	esic_delay #(.W(32), .N(MUL_LAT)) u_dly_den (.clk(clk), .en(adv), .d(den_s12),
		.q(den_s14));

	// Pressure: division and the trailing corrections.
	logic [63:0] q_s80, q_s82, q_s84, ps, pss_s82, c2p_s82, c1p_s84, c2p_s84;
	logic        pv_s14, pv_s84;

	assign pv_s14 = den_s14 != 32'd0;

	esic_div u_div (.clk(clk), .en(adv), .dividend(n_s14), .divisor(den_s14),
		.quotient(q_s80));
	esic_delay #(.W(1), .N(OUT_LAT - 1 - 14)) u_dly_pv (.clk(clk), .en(adv), .d(pv_s14),
		.q(pv_s84));

	assign ps = $signed(q_s80) >>> 13;

	esic_mul64 u_mul_pss (.clk(clk), .en(adv), .a(ps), .b(ps), .p(pss_s82));
	esic_mul64 u_mul_c2 (.clk(clk), .en(adv), .a(q_s80), .b(p8s), .p(c2p_s82));
	esic_delay #(.W(64), .N(MUL_LAT)) u_dly_q1 (.clk(clk), .en(adv), .d(q_s80), .q(q_s82));
	esic_mul64 u_mul_c1 (.clk(clk), .en(adv), .a(pss_s82), .b(p9s), .p(c1p_s84));
	esic_delay #(.W(64), .N(MUL_LAT)) u_dly_c2 (.clk(clk), .en(adv), .d(c2p_s82),
		.q(c2p_s84));
	esic_delay #(.W(64), .N(MUL_LAT)) u_dly_q2 (.clk(clk), .en(adv), .d(q_s82), .q(q_s84));

	// Temperature and humidity wait for the pressure path.
	logic [31:0] temp_s84, tfine_s84;
	logic [16:0] hum_s84;

	esic_delay #(.W(32), .N(OUT_LAT - 1 - 4)) u_dly_temp (.clk(clk), .en(adv),
		.d(temp_s4), .q(temp_s84));
	esic_delay #(.W(32), .N(OUT_LAT - 1 - 4)) u_dly_tfine (.clk(clk), .en(adv),
		.d(tfine_s4), .q(tfine_s84));
	esic_delay #(.W(17), .N(OUT_LAT - 1 - 11)) u_dly_hum (.clk(clk), .en(adv),
		.d(hum_s11), .q(hum_s84));

	// Output register.
	logic [63:0] c1sh, c2sh, psum, pfin;
	logic [31:0] temp_s85, tfine_s85, press_s85;
	logic        pv_s85;
	logic [16:0] hum_s85;

	always_comb begin
		c1sh = $signed(c1p_s84) >>> 25;
		c2sh = $signed(c2p_s84) >>> 19;
		psum = q_s84 + c1sh + c2sh;
		pfin = ($signed(psum) >>> 8) + (p7s << 4);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			temp_s85  <= temp_s84;
			tfine_s85 <= tfine_s84;
			press_s85 <= pv_s84 ? pfin[31:0] : 32'd0;
			pv_s85    <= pv_s84;
			hum_s85   <= hum_s84;
		end
	end

	assign out_ch.valid             = vld_q[OUT_LAT];
	assign out_ch.temperature_centi = temp_s85;
	assign out_ch.fine_temperature  = tfine_s85;
	assign out_ch.pressure_q24_8    = press_s85;
	assign out_ch.pressure_valid    = pv_s85;
	assign out_ch.humidity_q22_10   = hum_s85;
endmodule

>>> rtl/core/esic_checker.sv
// ----------------------------------------------------------------------------
// esic_checker
// Port-level checks of the compensation block, bound to its top level.
// ----------------------------------------------------------------------------
module esic_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] temperature_centi,
	input logic [31:0] fine_temperature,
	input logic [31:0] pressure_q24_8,
	input logic        pressure_valid,
	input logic [16:0] humidity_q22_10
);
	logic [31:0] t_round;
	logic [31:0] t_expect;

	// Temperature follows from the fine temperature of the same item.
	assign t_round  = fine_temperature * 32'd5 + 32'd128;
	assign t_expect = $signed(t_round) >>> 8;

	// A stalled result item holds its pressure, fine temperature and humidity.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pressure_q24_8)
		&& $stable(fine_temperature) && $stable(humidity_q22_10))
		else $error("result item changed while stalled");

	// The input side is held only by a stalled result.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	a_press_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pressure_valid |-> pressure_q24_8 == 32'd0)
		else $error("pressure nonzero without valid divisor");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> humidity_q22_10 <= 17'd102400)
		else $error("humidity above clamp");

	a_temp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_valid |-> temperature_centi == t_expect)
		else $error("temperature disagrees with fine temperature");
endmodule

bind env_sensor_integer_compensation esic_checker u_esic_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_ch.valid),
	.in_ready          (in_ch.ready),
	.out_valid         (out_ch.valid),
	.out_ready         (out_ch.ready),
	.temperature_centi (out_ch.temperature_centi),
	.fine_temperature  (out_ch.fine_temperature),
	.pressure_q24_8    (out_ch.pressure_q24_8),
	.pressure_valid    (out_ch.pressure_valid),
	.humidity_q22_10   (out_ch.humidity_q22_10)
);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the integer sensor compensation pipeline. Raw sample
// items are streamed through the input channel under several calibration
// settings, written over APB while the pipeline is idle. Each result item is
// compared field by field with an in-bench predictor of the compensation math.
// ----------------------------------------------------------------------------
module tb
	import esic_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  STALL_LIMIT  = 3000;
	localparam int  DRAIN_CYCLES = 100;
	localparam int  RAND_PER_SET = 130;
	localparam logic [2:0] UNMAPPED_REG = 3'd5;

	typedef struct {
		logic [19:0] raw_t;
		logic [19:0] raw_p;
		logic [15:0] raw_h;
	} sample_t;

	typedef struct {
		logic [31:0] temp;
		logic [31:0] tfine;
		logic [31:0] press;
		logic        pvalid;
		logic [16:0] hum;
	} comp_t;

	// Arithmetic right shifts at the block's two widths.
	function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [63:0] sra64(input logic [63:0] x, input int n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [31:0] sx32(input logic [15:0] v, input int bits);
		logic [31:0] r;
		r = {16'b0, v};
		for (int i = bits; i < 32; i++) r[i] = v[bits-1];
		return r;
	endfunction

	function automatic logic [63:0] sx64(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	// Signed 64-bit quotient truncated toward zero; the overflow case wraps.
	function automatic logic [63:0] quot64(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] ma, mb, q;
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		q  = ma / mb;
		return (a[63] != b[63]) ? -q : q;
	endfunction

	// Predicts compensation results and holds them until the pipeline delivers.
	class comp_scoreboard;
		logic [63:0] coeff [5];
		comp_t       pending_q [$];
		int          errors;

		function new();
			foreach (coeff[i]) coeff[i] = '0;
			errors = 0;
		endfunction

		function void set_coeff(input logic [2:0] idx, input logic [63:0] value);
			case (idx)
				REG_TEMP:     coeff[REG_TEMP]     = value & 64'h0000_FFFF_FFFF_FFFF;
				REG_PRESS_LO: coeff[REG_PRESS_LO] = value;
				REG_PRESS_HI: coeff[REG_PRESS_HI] = value;
				REG_MIXED:    coeff[REG_MIXED]    = value & 64'h00FF_FFFF_FFFF_FFFF;
				REG_HUM:      coeff[REG_HUM]      = value & 64'h0000_0000_00FF_FFFF;
				default: ;
			endcase
		endfunction

		function comp_t compensate(input sample_t s);
			comp_t r;
			logic [31:0] t1, t2, t3, v1, v2, d, tf;
			logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p, ps, c1, c2;
			logic [31:0] h1, h2, h3, h4, h5, h6, x, f1, f2, g, xs;
			logic [63:0] tc, pl, ph, mx, hc;
			tc = coeff[REG_TEMP];
			pl = coeff[REG_PRESS_LO];
			ph = coeff[REG_PRESS_HI];
			mx = coeff[REG_MIXED];
			hc = coeff[REG_HUM];
			t1 = {16'b0, tc[15:0]};
			t2 = sx32(tc[31:16], 16);
			t3 = sx32(tc[47:32], 16);
			p1 = {48'b0, pl[15:0]};
			p2 = sx64(pl[31:16]);
			p3 = sx64(pl[47:32]);
			p4 = sx64(pl[63:48]);
			p5 = sx64(ph[15:0]);
			p6 = sx64(ph[31:16]);
			p7 = sx64(ph[47:32]);
			p8 = sx64(ph[63:48]);
			p9 = sx64(mx[15:0]);
			h1 = {24'b0, mx[23:16]};
			h2 = sx32(mx[39:24], 16);
			h3 = {24'b0, mx[47:40]};
			h6 = sx32({8'b0, mx[55:48]}, 8);
			h4 = sx32({4'b0, hc[11:0]}, 12);
			h5 = sx32({4'b0, hc[23:12]}, 12);

			// Temperature and fine temperature.
			v1 = ({12'b0, s.raw_t} >> 3) - (t1 << 1);
			v1 = sra32(v1 * t2, 11);
			d  = ({12'b0, s.raw_t} >> 4) - t1;
			v2 = d * d;
			v2 = sra32(sra32(v2, 12) * t3, 14);
			tf = v1 + v2;
			r.tfine = tf;
			r.temp  = sra32(tf * 32'd5 + 32'd128, 8);

			// Pressure, with a divisor that may come out zero.
			a = {{32{tf[31]}}, tf} - 64'd128000;
			b = a * a * p6;
			b = b + ((a * p5) << 17);
			b = b + (p4 << 35);
			a = sra64(a * a * p3, 8) + ((a * p2) << 12);
			a = sra64(((64'd1 << 47) + a) * p1, 33);
			r.press  = '0;
			r.pvalid = 1'b0;
			if (a != 0) begin
				p  = 64'd1048576 - {44'b0, s.raw_p};
				p  = quot64(((p << 31) - b) * 64'd3125, a);
				ps = sra64(p, 13);
				c1 = sra64(p9 * ps * ps, 25);
				c2 = sra64(p8 * p, 19);
				p  = sra64(p + c1 + c2, 8) + (p7 << 4);
				r.press  = p[31:0];
				r.pvalid = 1'b1;
			end

			// Humidity, clamped before the final shift.
			r.hum = '0;
			x = tf - 32'd76800;
			if (x != 0) begin
				f1 = sra32(({16'b0, s.raw_h} << 14) - (h4 << 20) - (h5 * x) + 32'd16384, 15);
				g  = sra32(x * h6, 10) * (sra32(x * h3, 11) + 32'd32768);
				f2 = sra32((sra32(g, 10) + 32'd2097152) * h2 + 32'd8192, 14);
				x  = f1 * f2;
				xs = sra32(x, 15);
				x  = x - sra32(sra32(xs * xs, 7) * h1, 4);
				if ($signed(x) < 0) x = '0;
				if ($signed(x) > 32'sd419430400) x = 32'd419430400;
				x = x >> 12;
				r.hum = x[16:0];
			end
			return r;
		endfunction

		function void note_sample(input sample_t s);
			pending_q.push_back(compensate(s));
		endfunction

		function void check_result(input comp_t got);
			comp_t want;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result item temp=%0d", $realtime, $signed(got.temp));
				errors++;
				return;
			end
			want = pending_q.pop_front();
			if (got.temp !== want.temp) begin
				$display("%0t: temperature_centi expected %0d actual %0d", $realtime,
					$signed(want.temp), $signed(got.temp));
				errors++;
			end
			if (got.tfine !== want.tfine) begin
				$display("%0t: fine_temperature expected %0d actual %0d", $realtime,
					$signed(want.tfine), $signed(got.tfine));
				errors++;
			end
			if (got.press !== want.press) begin
				$display("%0t: pressure_q24_8 expected %h actual %h", $realtime,
					want.press, got.press);
				errors++;
			end
			if (got.pvalid !== want.pvalid) begin
				$display("%0t: pressure_valid expected %b actual %b", $realtime,
					want.pvalid, got.pvalid);
				errors++;
			end
			if (got.hum !== want.hum) begin
				$display("%0t: humidity_q22_10 expected %0d actual %0d", $realtime,
					want.hum, got.hum);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	int sender_idle_pct;
	int receiver_stall_pct;
	int quiet_cycles;

	comp_scoreboard sb;

	esic_in_if  in_ch ();
	esic_out_if out_ch ();

	env_sensor_integer_compensation dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch.sink),
		.out_ch  (out_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Result side: random back-pressure, driven at the falling edge.
	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Result checking and the watchdog on accepted items.
	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			sb.check_result('{out_ch.temperature_centi, out_ch.fine_temperature,
				out_ch.pressure_q24_8, out_ch.pressure_valid, out_ch.humidity_q22_10});
		end
		if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// One APB write: setup cycle, then access cycle.
	task automatic write_coeff(input logic [2:0] idx, input logic [63:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (pready) sb.set_coeff(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_all(input logic [63:0] tc, input logic [63:0] pl,
		input logic [63:0] ph, input logic [63:0] mx, input logic [63:0] hc);
		write_coeff(REG_TEMP, tc);
		write_coeff(REG_PRESS_LO, pl);
		write_coeff(REG_PRESS_HI, ph);
		write_coeff(REG_MIXED, mx);
		write_coeff(REG_HUM, hc);
	endtask

	// Sends one item, leaving valid high after acceptance; the caller is at
	// a falling edge on entry and on return.
	task automatic send_sample(input logic [19:0] rt, input logic [19:0] rp,
		input logic [15:0] rh);
		int gap;
		gap = 0;
		if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(1, 4);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid           <= 1'b1;
		in_ch.raw_temperature <= rt;
		in_ch.raw_pressure    <= rp;
		in_ch.raw_humidity    <= rh;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_sample('{rt, rp, rh});
		@(negedge clk);
	endtask

	task automatic send_random();
		if ($urandom_range(1)) begin
			send_sample(20'($urandom), 20'($urandom), 16'($urandom));
		end else begin
			send_sample(20'($urandom_range(420000, 620000)),
				20'($urandom_range(250000, 500000)),
				16'($urandom_range(20000, 45000)));
		end
	endtask

	// Waits until every expected result has arrived, with the valid low.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode % 4)
			0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
			1: begin sender_idle_pct = 63; receiver_stall_pct = 0;  end
			2: begin sender_idle_pct = 0;  receiver_stall_pct = 63; end
			default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
		endcase
	endtask

	// Stimulus: reset, then one phase per calibration setting.
	initial begin
		sb = new();
		sender_idle_pct       = 0;
		receiver_stall_pct    = 0;
		quiet_cycles          = 0;
		arst_n                = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		in_ch.valid           = 1'b0;
		in_ch.raw_temperature = '0;
		in_ch.raw_pressure    = '0;
		in_ch.raw_humidity    = '0;
		out_ch.ready          = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < 8; ph++) begin
			set_idling(ph);
			case (ph)
				// Reset coefficients: zero divisor throughout.
				0: write_coeff(UNMAPPED_REG, 64'hFFFF_FFFF_FFFF_FFFF);
				// Typical calibration data.
				1: write_all({16'hFC18, 16'd26435, 16'd27504},
					{16'd2855, 16'd3024, 16'hD643, 16'd36477},
					{16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
					{8'd30, 8'd0, 16'd362, 8'd75, 16'd6000},
					{12'd50, 12'd313});
				// Fine temperature equals raw_t >> 3, so 76800 is reachable.
				2: write_all({16'd0, 16'd2048, 16'd0},
					{16'd2855, 16'd3024, 16'hD643, 16'd36477},
					{16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
					{8'd30, 8'd0, 16'd362, 8'd75, 16'd6000},
					{12'd50, 12'd313});
				// All ones, with bits above each register's width.
				3: write_all('1, '1, '1, '1, '1);
				// Most negative signed fields, largest unsigned ones.
				4: write_all({16'h8000, 16'h8000, 16'hFFFF},
					{16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
					{16'h8000, 16'h8000, 16'h8000, 16'h8000},
					{8'h80, 8'hFF, 16'h8000, 8'hFF, 16'h8000},
					{12'h800, 12'h800});
				default: write_all({$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
			endcase

			// Directed items: field extremes and the special cases.
			if (ph <= 2) begin
				send_sample('0, '0, '0);
				send_sample('1, '1, '1);
				send_sample(20'hAAAAA, 20'h55555, 16'hAAAA);
				send_sample(20'h55555, 20'hAAAAA, 16'h5555);
				send_sample(20'd519888, 20'd415148, 16'd30000);
			end
			if (ph == 2) begin
				send_sample(20'd614400, 20'd415148, 16'd30000);
				send_sample(20'd614407, 20'd0, 16'hFFFF);
				send_sample(20'd614399, 20'hFFFFF, 16'd0);
				send_sample(20'd614408, 20'd300000, 16'd40000);
			end

			for (int n = 0; n < RAND_PER_SET; n++) begin
				// Once, hold the sender until the pipeline has emptied.
				if (ph == 5 && n == 60) drain();
				send_random();
			end
			drain();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/esic_pkg.sv
rtl/core/esic_if.sv
rtl/core/esic_mul64.sv
rtl/core/esic_delay.sv
rtl/core/esic_div.sv
rtl/core/env_sensor_integer_compensation.sv
rtl/core/esic_checker.sv
tb/tb.sv
